>>> hdl/per_core_page_free_list_allocator_top_defines.svh
// Assertion macros for the page allocator checker.
`ifndef PER_CORE_PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PER_CORE_PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define PFLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define PFLA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pfla_pkg.sv
// Shared constants, codes and control types for the page allocator.
package pfla_pkg;

    localparam int CORES      = 8;
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W     = 35;
    localparam int CORE_W     = 3;
    localparam int CORE_IDX_W = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0] KERNEL_END_RESET = 35'h0_8000_0000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RESET   = 35'h0_8800_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ADDR = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic commit_free;
        logic start_read;
        logic commit_pop;
        logic commit_empty;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_free;
        logic any_valid;
    } dp_status_t;

endpackage

>>> hdl/pfla_ctrl.sv
// Controller state machine sequencing free and allocate transactions.
module pfla_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  pfla_pkg::dp_status_t  dp_status,
    output pfla_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_room;
    logic   commit;

    assign out_room  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign commit    = cmd.commit_free || cmd.commit_pop || cmd.commit_empty;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dp_status.op_free)
                begin
                    if (out_room)
                    begin
                        cmd.commit_free = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (dp_status.any_valid)
                begin
                    cmd.start_read = 1'b1;
                    state_next     = S_READ;
                end
                else if (out_room)
                begin
                    cmd.commit_empty = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_room)
                begin
                    cmd.commit_pop = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/pfla_datapath.sv
// Datapath: configuration, list heads, next-link memory and result register.
module pfla_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfla_pkg::ctrl_cmd_t                cmd,
    output pfla_pkg::dp_status_t               dp_status,
    input  logic                               operation,
    input  logic [pfla_pkg::CORE_W-1:0]        core_id,
    input  logic [pfla_pkg::ADDR_W-1:0]        page_addr,
    input  logic                               cfg_write_en,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfla_pkg::ADDR_W-1:0]        cfg_data,
    output logic [pfla_pkg::ADDR_W-1:0]        granted_addr,
    output logic [1:0]                         status,
    output logic [pfla_pkg::CORE_W-1:0]        source_core
);

    localparam logic [pfla_pkg::ADDR_W:0] PAGE_MASK =
        (pfla_pkg::ADDR_W+1)'((1 << pfla_pkg::PAGE_SHIFT) - 1);

    logic [pfla_pkg::ADDR_W-1:0]     kernel_end_reg;
    logic [pfla_pkg::ADDR_W-1:0]     phys_top_reg;
    logic [pfla_pkg::ADDR_W:0]       base_reg;
    logic [pfla_pkg::ADDR_W:0]       base_next;

    logic                            op_reg;
    logic [pfla_pkg::CORE_IDX_W-1:0] core_reg;
    logic [pfla_pkg::ADDR_W-1:0]     pa_reg;
    logic [pfla_pkg::CORE_IDX_W-1:0] sel_reg;

    logic [pfla_pkg::IDX_W-1:0]      head_idx_reg [pfla_pkg::CORES];
    logic [pfla_pkg::CORES-1:0]      head_valid_reg;
    logic [pfla_pkg::LINK_W-1:0]     link_mem [pfla_pkg::MAX_PAGES];
    logic [pfla_pkg::LINK_W-1:0]     rd_link_reg;

    logic [pfla_pkg::ADDR_W-1:0]     granted_reg;
    pfla_pkg::status_t               status_reg;
    logic [pfla_pkg::CORE_W-1:0]     source_reg;

    logic [pfla_pkg::ADDR_W:0]       diff;
    logic [pfla_pkg::IDX_W-1:0]      free_idx;
    logic                            free_ok;
    logic                            any_valid;
    logic [pfla_pkg::CORE_IDX_W-1:0] sel_core;
    logic [pfla_pkg::CORE_IDX_W-1:0] rd_core;
    logic [pfla_pkg::CORE_IDX_W-1:0] wr_core;
    logic [pfla_pkg::IDX_W-1:0]      head_rd_idx;
    logic [pfla_pkg::ADDR_W:0]       pop_sum;

    assign base_next = ({1'b0, cfg_data} + PAGE_MASK) & ~PAGE_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg <= pfla_pkg::KERNEL_END_RESET;
            phys_top_reg   <= pfla_pkg::PHYS_TOP_RESET;
            base_reg       <= {1'b0, pfla_pkg::KERNEL_END_RESET};
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                pfla_pkg::CFG_KERNEL_END:
                begin
                    kernel_end_reg <= cfg_data;
                    base_reg       <= base_next;
                end
                pfla_pkg::CFG_PHYS_TOP:
                begin
                    phys_top_reg <= cfg_data;
                end
                default:
                begin
                    phys_top_reg <= phys_top_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            core_reg <= core_id[pfla_pkg::CORE_IDX_W-1:0];
            pa_reg   <= page_addr;
        end
        if (cmd.start_read)
        begin
            sel_reg <= sel_core;
        end
    end

    assign diff     = {1'b0, pa_reg} - base_reg;
    assign free_idx = diff[pfla_pkg::PAGE_SHIFT +: pfla_pkg::IDX_W];
    assign free_ok  = (pa_reg[pfla_pkg::PAGE_SHIFT-1:0] == '0)
                   && (pa_reg >= kernel_end_reg)
                   && (pa_reg < phys_top_reg)
                   && ({1'b0, pa_reg} >= base_reg)
                   && ((diff >> (pfla_pkg::PAGE_SHIFT + pfla_pkg::IDX_W)) == '0);

    always_comb
    begin
        logic [pfla_pkg::CORE_IDX_W-1:0] cand;
        any_valid = 1'b0;
        sel_core  = '0;
        for (int k = pfla_pkg::CORES - 1; k >= 0; k--)
        begin
            cand = core_reg + pfla_pkg::CORE_IDX_W'(k);
            if (head_valid_reg[cand])
            begin
                any_valid = 1'b1;
                sel_core  = cand;
            end
        end
    end

    assign dp_status.op_free   = (op_reg == pfla_pkg::OP_FREE);
    assign dp_status.any_valid = any_valid;

    assign rd_core     = cmd.commit_pop ? sel_reg
                       : (dp_status.op_free ? core_reg : sel_core);
    assign wr_core     = cmd.commit_pop ? sel_reg : core_reg;
    assign head_rd_idx = head_idx_reg[rd_core];

    assign pop_sum = base_reg
                   + ({{(pfla_pkg::ADDR_W + 1 - pfla_pkg::IDX_W){1'b0}}, head_rd_idx}
                      << pfla_pkg::PAGE_SHIFT);

    always_ff @(posedge clk)
    begin
        if (cmd.commit_free && free_ok)
        begin
            link_mem[free_idx] <= {head_valid_reg[rd_core], head_rd_idx};
        end
        if (cmd.start_read)
        begin
            rd_link_reg <= link_mem[head_rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_free && free_ok)
        begin
            head_idx_reg[wr_core] <= free_idx;
        end
        else if (cmd.commit_pop)
        begin
            head_idx_reg[wr_core] <= rd_link_reg[pfla_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
        end
        else if (cmd.commit_free && free_ok)
        begin
            head_valid_reg[wr_core] <= 1'b1;
        end
        else if (cmd.commit_pop)
        begin
            head_valid_reg[wr_core] <= rd_link_reg[pfla_pkg::IDX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_free)
        begin
            granted_reg <= '0;
            source_reg  <= '0;
            status_reg  <= free_ok ? pfla_pkg::ST_OK : pfla_pkg::ST_BAD_ADDR;
        end
        else if (cmd.commit_empty)
        begin
            granted_reg <= '0;
            source_reg  <= '0;
            status_reg  <= pfla_pkg::ST_EMPTY;
        end
        else if (cmd.commit_pop)
        begin
            granted_reg <= pop_sum[pfla_pkg::ADDR_W-1:0];
            source_reg  <= pfla_pkg::CORE_W'(sel_reg);
            status_reg  <= pfla_pkg::ST_OK;
        end
    end

    assign granted_addr = granted_reg;
    assign status       = status_reg;
    assign source_core  = source_reg;

endmodule

>>> hdl/per_core_page_free_list_allocator_top.sv
// Top level of the per-core page free list allocator.
// Input channel (in_valid/in_stall) carries one transaction: operation 1 frees
// page_addr onto core_id's list, operation 0 allocates a page for core_id.
// Output channel (out_valid/out_stall) returns exactly one result per input:
// granted_addr, status (ok, no free page, bad free address) and source_core.
// An allocation first pops core_id's list, then the other cores round robin.
// A free's result is registered from the execute step; an allocation that finds
// a page passes head selection, then the registered next-link memory read,
// and one that finds none returns from head selection. The block takes one
// transaction at a time and accepts the next once the last has been committed.
// The result register decouples the sides: a new input is taken while a result
// still waits; the block holds its final step while out_stall is high and the
// result register is full. Configuration writes (cfg_write_en, cfg_index,
// cfg_data) take effect at once and are expected only while the block is idle.
// Reset clears every list and restores the default memory bounds; the
// next-link memory needs no clearing, so the block is ready right after reset.
module per_core_page_free_list_allocator_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [pfla_pkg::CORE_W-1:0]        core_id,
    input  logic [pfla_pkg::ADDR_W-1:0]        page_addr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pfla_pkg::ADDR_W-1:0]        granted_addr,
    output logic [1:0]                         status,
    output logic [pfla_pkg::CORE_W-1:0]        source_core,
    input  logic                               cfg_write_en,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfla_pkg::ADDR_W-1:0]        cfg_data
);

    pfla_pkg::ctrl_cmd_t  cmd;
    pfla_pkg::dp_status_t dp_status;

    pfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    pfla_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .operation    (operation),
        .core_id      (core_id),
        .page_addr    (page_addr),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .granted_addr (granted_addr),
        .status       (status),
        .source_core  (source_core)
    );

endmodule

>>> hdl/pfla_checker.sv
// Port-level checker for the page allocator and its bind.
`include "per_core_page_free_list_allocator_top_defines.svh"

module pfla_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               operation,
    input  logic [pfla_pkg::CORE_W-1:0]        core_id,
    input  logic [pfla_pkg::ADDR_W-1:0]        page_addr,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [pfla_pkg::ADDR_W-1:0]        granted_addr,
    input  logic [1:0]                         status,
    input  logic [pfla_pkg::CORE_W-1:0]        source_core,
    input  logic                               cfg_write_en,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfla_pkg::ADDR_W-1:0]        cfg_data
);

    `PFLA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    `PFLA_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(granted_addr) && $stable(status) && $stable(source_core), "stalled result changed")

    `PFLA_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second transaction taken while busy")

    `PFLA_ASSERT_ALWAYS(a_fail_zero, out_valid && (status != pfla_pkg::ST_OK) |-> (granted_addr == '0) && (source_core == '0), "failed result carries an address")

endmodule

bind per_core_page_free_list_allocator_top pfla_checker u_pfla_checker (.*);

>>> tb/pfla_grant_checker.sv
`timescale 1ns / 100ps
// Grant checker: predicts every allocator transaction and compares the returned results.
module pfla_grant_checker
    import pfla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              operation,
    input  logic [CORE_W-1:0] core_id,
    input  logic [ADDR_W-1:0] page_addr,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [ADDR_W-1:0] granted_addr,
    input  logic [1:0]        status,
    input  logic [CORE_W-1:0] source_core,
    input  logic              cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           st;
        logic [CORE_W-1:0] src;
    } grant_t;

    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

    logic [ADDR_W-1:0] kernel_end;
    logic [ADDR_W-1:0] phys_top;
    logic [IDX_W-1:0]  head_idx [CORES];
    logic              head_ok  [CORES];
    logic [IDX_W-1:0]  link_idx [MAX_PAGES];
    logic              link_ok  [MAX_PAGES];
    grant_t            expected_grants [$];
    grant_t            want;
    int                mismatches;

    function automatic grant_t serve_request(input logic op, input logic [CORE_W-1:0] core,
                                             input logic [ADDR_W-1:0] pa);
        grant_t           g;
        logic [ADDR_W:0]  base;
        logic [ADDR_W:0]  offset;
        logic [ADDR_W:0]  page;
        logic [IDX_W-1:0] idx;
        int               home;
        int               j;
        bit               found;
        g.addr = '0;
        g.st   = ST_OK;
        g.src  = '0;
        base   = ({1'b0, kernel_end} + PAGE_MASK) & ~PAGE_MASK;
        home   = int'(core) % CORES;
        if (op == OP_FREE) begin
            if ((pa & PAGE_MASK[ADDR_W-1:0]) != 0 || pa < kernel_end || pa >= phys_top
                    || {1'b0, pa} < base) begin
                g.st = ST_BAD_ADDR;
            end
            else begin
                offset = ({1'b0, pa} - base) >> PAGE_SHIFT;
                if (offset >= MAX_PAGES) begin
                    g.st = ST_BAD_ADDR;
                end
                else begin
                    idx            = offset[IDX_W-1:0];
                    link_idx[idx]  = head_idx[home];
                    link_ok[idx]   = head_ok[home];
                    head_idx[home] = idx;
                    head_ok[home]  = 1'b1;
                end
            end
        end
        else begin
            found = 1'b0;
            for (int k = 0; k < CORES; k++) begin
                j = (home + k) % CORES;
                if (!found && head_ok[j]) begin
                    found       = 1'b1;
                    idx         = head_idx[j];
                    page        = {{(ADDR_W + 1 - IDX_W){1'b0}}, idx};
                    page        = base + (page << PAGE_SHIFT);
                    g.addr      = page[ADDR_W-1:0];
                    g.src       = j[CORE_W-1:0];
                    head_idx[j] = link_idx[idx];
                    head_ok[j]  = link_ok[idx];
                end
            end
            if (!found)
                g.st = ST_EMPTY;
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end = KERNEL_END_RESET;
            phys_top   = PHYS_TOP_RESET;
            for (int c = 0; c < CORES; c++)
            begin
                head_idx[c] = '0;
                head_ok[c]  = 1'b0;
            end
            expected_grants.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("unexpected result: granted_addr %h status %0d source_core %0d",
                           granted_addr, status, source_core);
                    mismatches++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (granted_addr !== want.addr)
                    begin
                        $error("granted_addr: expected %h, actual %h", want.addr, granted_addr);
                        mismatches++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        mismatches++;
                    end
                    if (source_core !== want.src)
                    begin
                        $error("source_core: expected %0d, actual %0d", want.src, source_core);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_grants.push_back(serve_request(operation, core_id, page_addr));
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_KERNEL_END)
                    kernel_end = cfg_data;
                else if (cfg_index == CFG_PHYS_TOP)
                    phys_top = cfg_data;
            end
            fail_count    <= mismatches;
            pending_count <= expected_grants.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives page frees, allocations and bound writes, and gives the verdict.
module tb_top;
    import pfla_pkg::*;

    localparam int              CYCLE_LIMIT = 1000000;
    localparam longint unsigned PAGE_BYTES  = 64'd1 << PAGE_SHIFT;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [CORE_W-1:0]    core_id;
    logic [ADDR_W-1:0]    page_addr;
    logic                 out_valid;
    logic                 out_stall;
    logic [ADDR_W-1:0]    granted_addr;
    logic [1:0]           status;
    logic [CORE_W-1:0]    source_core;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    int                   alloc_pct;
    bit                   steady;
    logic [ADDR_W-1:0]    ke;
    logic [ADDR_W-1:0]    pt;

    per_core_page_free_list_allocator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .core_id      (core_id),
        .page_addr    (page_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_addr (granted_addr),
        .status       (status),
        .source_core  (source_core),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pfla_grant_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .core_id       (core_id),
        .page_addr     (page_addr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_addr  (granted_addr),
        .status        (status),
        .source_core   (source_core),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] free_addr();
        longint unsigned kl;
        longint unsigned tl;
        longint unsigned base;
        longint unsigned span;
        longint unsigned idx;
        longint unsigned pick;
        int              r;
        kl   = ke;
        tl   = pt;
        base = (kl + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
        span = (tl > base) ? (tl - base) >> PAGE_SHIFT : 0;
        if (span > MAX_PAGES + 4)
            span = MAX_PAGES + 4;
        if (span > 0)
        begin
            if (span > 64 && $urandom_range(0, 1) == 1)
                idx = $urandom_range(0, 63);
            else
                idx = $urandom % span;
            pick = base + (idx << PAGE_SHIFT);
        end
        else
            pick = rand_addr();
        r = $urandom_range(0, 99);
        if (r < 78)
            return ADDR_W'(pick);
        if (r < 84)
            return rand_addr();
        if (r < 90)
            return ADDR_W'(kl + $urandom_range(0, 16384) - 8192);
        if (r < 95)
            return ADDR_W'(tl + $urandom_range(0, 16384) - 8192);
        return ADDR_W'(pick + $urandom_range(1, PAGE_BYTES - 1));
    endfunction

    task automatic issue(input logic op, input logic [CORE_W-1:0] core,
                         input logic [ADDR_W-1:0] addr);
        int gap;
        in_valid  <= 1'b1;
        operation <= op;
        core_id   <= core;
        page_addr <= addr;
        do @(posedge clk); while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_bounds(input logic [ADDR_W-1:0] k, input logic [ADDR_W-1:0] t);
        ke = k;
        pt = t;
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_KERNEL_END;
        cfg_data     <= k;
        @(posedge clk);
        cfg_index    <= CFG_PHYS_TOP;
        cfg_data     <= t;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_run(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 25;
                    1:       alloc_pct = 50;
                    default: alloc_pct = 80;
                endcase
                steady = ($urandom_range(0, 4) == 0);
            end
            if (n == count / 2 && $urandom_range(0, 1) == 1)
                drain();
            if ($urandom_range(0, 99) < alloc_pct)
                issue(OP_ALLOC, CORE_W'($urandom), rand_addr());
            else
                issue(OP_FREE, CORE_W'($urandom), free_addr());
        end
        steady = 1'b0;
    endtask

    // hold stall off for a while, then stall briefly or, now and then, for long
    initial
    begin
        int len;
        forever
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
            repeat (len) @(posedge clk);
            out_stall <= 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            repeat (len) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_ALLOC;
        core_id      = '0;
        page_addr    = '0;
        out_stall    = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_KERNEL_END;
        cfg_data     = '0;
        alloc_pct    = 50;
        steady       = 1'b0;
        ke           = KERNEL_END_RESET;
        pt           = PHYS_TOP_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        issue(OP_ALLOC, 3'd0, 35'h0_0000_0000);
        issue(OP_FREE,  3'd3, 35'h0_8000_0000);
        issue(OP_FREE,  3'd3, 35'h0_87FF_F000);
        issue(OP_FREE,  3'd3, 35'h0_8000_0800);
        issue(OP_FREE,  3'd3, 35'h0_7FFF_F000);
        issue(OP_FREE,  3'd3, 35'h0_8800_0000);
        issue(OP_FREE,  3'd7, 35'h7_FFFF_FFFF);
        issue(OP_FREE,  3'd0, 35'h0_0000_0000);
        issue(OP_ALLOC, 3'd3, 35'h7_FFFF_FFFF);
        issue(OP_ALLOC, 3'd0, 35'h0_0000_0000);
        issue(OP_ALLOC, 3'd5, 35'h0_0000_0000);
        issue(OP_FREE,  3'd7, 35'h0_8000_1000);
        issue(OP_FREE,  3'd7, 35'h0_8000_1000);
        issue(OP_ALLOC, 3'd6, 35'h0_0000_0000);
        issue(OP_ALLOC, 3'd0, 35'h0_0000_0000);
        issue(OP_ALLOC, 3'd0, 35'h0_0000_0000);
        issue(OP_FREE,  3'd0, 35'h0_8000_2000);
        issue(OP_FREE,  3'd2, 35'h0_8000_3000);
        issue(OP_ALLOC, 3'd1, 35'h0_0000_0000);
        issue(OP_ALLOC, 3'd1, 35'h0_0000_0000);
        random_run(440);
        drain();

        write_bounds(35'h0_9000_0801, 35'h0_9100_0000);
        issue(OP_FREE, 3'd4, 35'h0_9000_0000);
        issue(OP_FREE, 3'd4, 35'h0_9000_1000);
        random_run(440);
        drain();

        write_bounds(35'h0_0000_0000, 35'h7_FFFF_FFFF);
        issue(OP_FREE,  3'd1, 35'h0_0000_0000);
        issue(OP_FREE,  3'd1, 35'h0_07FF_F000);
        issue(OP_FREE,  3'd1, 35'h0_0800_0000);
        issue(OP_ALLOC, 3'd4, 35'h0_0000_0000);
        random_run(440);
        drain();

        write_bounds(35'h7_FFFF_F001, 35'h7_FFFF_FFFF);
        random_run(80);
        drain();

        write_bounds(35'h7_FC00_0000, 35'h7_FFFF_FFFF);
        random_run(440);
        drain();

        write_bounds(35'h7_FFFF_FFFF, 35'h0_0000_0000);
        random_run(30);
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
